// ===== rtl/sbsm_pkg.sv =====
package sbsm_pkg;

  localparam int unsigned RegW  = 5;
  localparam int unsigned DataW = 8;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW  = 3;

  localparam logic [RegW-1:0] CtlResetVal = 5'h1F;
  localparam logic [RegW-1:0] MaskResetVal = 5'h1F;

  // mapper register select
  typedef enum logic [1:0] {
    SEL_CTRL = 2'd0,
    SEL_CHR0 = 2'd1,
    SEL_CHR1 = 2'd2,
    SEL_PRG  = 2'd3
  } sbsm_sel_t;

  // configuration register index
  typedef enum logic [1:0] {
    CFG_WRAM_SEL = 2'd0,
    CFG_PRG_MASK = 2'd1,
    CFG_CHR_MASK = 2'd2,
    CFG_UNUSED   = 2'd3
  } sbsm_cfg_idx_t;

  // control bits 3:2 PRG mode codes
  typedef enum logic [1:0] {
    PRG_32K_A   = 2'd0,
    PRG_32K_B   = 2'd1,
    PRG_FIX_LOW = 2'd2,
    PRG_FIX_HIGH = 2'd3
  } sbsm_prg_mode_t;

  typedef struct packed {
    logic [RegW-1:0] ctl;
    logic [RegW-1:0] chr0;
    logic [RegW-1:0] chr1;
    logic [RegW-1:0] prg;
  } sbsm_regs_t;

  typedef struct packed {
    logic            wram_sel_en;
    logic [RegW-1:0] prg_mask;
    logic [RegW-1:0] chr_mask;
  } sbsm_cfg_t;

  typedef struct packed {
    logic [RegW-1:0] prg_bank_low;
    logic [RegW-1:0] prg_bank_high;
    logic [RegW-1:0] chr_bank_low;
    logic [RegW-1:0] chr_bank_high;
    logic [1:0]      mirror_mode;
    logic            wram_enabled;
    logic            wram_bank;
    logic            write_ignored;
  } sbsm_result_t;

endpackage

// ===== rtl/sbsm_state.sv =====
module sbsm_state import sbsm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [1:0]       reg_select,
  input  logic [DataW-1:0] write_data,
  input  logic [TimeW-1:0] cpu_time,
  output sbsm_regs_t       regs_nxt,
  output logic             ignored
);

  sbsm_regs_t       regs_r;
  logic [RegW-1:0]  shift_buf_r, shift_buf_nxt, shift_buf_or;
  logic [CntW-1:0]  shift_cnt_r, shift_cnt_nxt;
  logic [TimeW-1:0] last_rst_r, last_rst_nxt;
  logic [TimeW-1:0] time_diff;
  logic [RegW-1:0]  serial_bit;

  assign time_diff  = cpu_time - last_rst_r;
  assign ignored    = (time_diff[TimeW-1:1] == '0);
  assign serial_bit = RegW'(write_data[0]) << shift_cnt_r;
  assign shift_buf_or = shift_buf_r | serial_bit;

  always_comb begin
    regs_nxt      = regs_r;
    shift_buf_nxt = shift_buf_r;
    shift_cnt_nxt = shift_cnt_r;
    last_rst_nxt  = last_rst_r;
    if (!ignored) begin
      if (write_data[DataW-1]) begin
        regs_nxt.ctl  = regs_r.ctl | 5'b01100;
        shift_buf_nxt = '0;
        shift_cnt_nxt = '0;
        last_rst_nxt  = cpu_time;
      end else if (shift_cnt_r == CntW'(RegW - 1)) begin
        // fifth bit: commit the whole word to the selected register
        unique case (sbsm_sel_t'(reg_select))
          SEL_CTRL: regs_nxt.ctl  = shift_buf_or;
          SEL_CHR0: regs_nxt.chr0 = shift_buf_or;
          SEL_CHR1: regs_nxt.chr1 = shift_buf_or;
          SEL_PRG:  regs_nxt.prg  = shift_buf_or;
          default:  regs_nxt      = regs_r;
        endcase
        shift_buf_nxt = '0;
        shift_cnt_nxt = '0;
      end else begin
        shift_buf_nxt = shift_buf_or;
        shift_cnt_nxt = shift_cnt_r + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r      <= '{ctl: CtlResetVal, chr0: '0, chr1: '0, prg: '0};
      shift_buf_r <= '0;
      shift_cnt_r <= '0;
      last_rst_r  <= '0;
    end else if (advance) begin
      regs_r      <= regs_nxt;
      shift_buf_r <= shift_buf_nxt;
      shift_cnt_r <= shift_cnt_nxt;
      last_rst_r  <= last_rst_nxt;
    end
  end

endmodule

// ===== rtl/sbsm_map.sv =====
module sbsm_map import sbsm_pkg::*; (
  input  sbsm_regs_t   regs,
  input  sbsm_cfg_t    cfg,
  input  logic         ignored,
  output sbsm_result_t res
);

  logic [RegW-1:0] offs, bank, plo, phi, clo, chi;

  assign offs = {regs.chr0[4], 4'b0000};
  assign bank = {1'b0, regs.prg[3:0]};

  always_comb begin
    unique case (sbsm_prg_mode_t'(regs.ctl[3:2]))
      PRG_FIX_HIGH: begin
        plo = bank + offs;
        phi = 5'h0F + offs;
      end
      PRG_FIX_LOW: begin
        plo = offs;
        phi = bank + offs;
      end
      PRG_32K_A, PRG_32K_B: begin
        plo = (bank & 5'h0E) + offs;
        phi = ((bank & 5'h0E) + offs) | 5'h01;
      end
      default: begin
        plo = '0;
        phi = '0;
      end
    endcase

    if (regs.ctl[4]) begin
      clo = regs.chr0;
      chi = regs.chr1;
    end else begin
      clo = regs.chr0 & 5'h1E;
      chi = regs.chr0 | 5'h01;
    end

    res.prg_bank_low  = plo & cfg.prg_mask;
    res.prg_bank_high = phi & cfg.prg_mask;
    res.chr_bank_low  = clo & cfg.chr_mask;
    res.chr_bank_high = chi & cfg.chr_mask;
    res.mirror_mode   = regs.ctl[1:0];
    res.wram_enabled  = ~regs.prg[4];
    res.wram_bank     = cfg.wram_sel_en & (regs.ctl[4] ? regs.chr0[4] : regs.chr0[3]);
    res.write_ignored = ignored;
  end

endmodule

// ===== rtl/serial_bank_switch_mapper.sv =====
// Pipeline: input register, then state update and bank mapping into the
// result register.
// Throughput: one transaction per cycle; the input side stalls only while a
// result is held and the output is stalled.
// Reset (rst_n low, synchronous): control register 0x1F, others zero, shifter
// empty, last reset time zero, masks 31, work RAM bank select off.
module serial_bank_switch_mapper import sbsm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_reg_select,
  input  logic [DataW-1:0] in_write_data,
  input  logic [TimeW-1:0] in_cpu_time,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [RegW-1:0]  out_prg_bank_low,
  output logic [RegW-1:0]  out_prg_bank_high,
  output logic [RegW-1:0]  out_chr_bank_low,
  output logic [RegW-1:0]  out_chr_bank_high,
  output logic [1:0]       out_mirror_mode,
  output logic             out_wram_enabled,
  output logic             out_wram_bank,
  output logic             out_write_ignored,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [RegW-1:0]  cfg_data
);

  logic             s1_valid_r;
  logic [1:0]       s1_sel_r;
  logic [DataW-1:0] s1_data_r;
  logic [TimeW-1:0] s1_time_r;
  logic             out_valid_r;
  sbsm_result_t     res_r, res_nxt;
  sbsm_cfg_t        cfg_r;
  sbsm_regs_t       regs_nxt;
  logic             ignored;
  logic             advance, in_take;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sel_r  <= in_reg_select;
      s1_data_r <= in_write_data;
      s1_time_r <= in_cpu_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{wram_sel_en: 1'b0, prg_mask: MaskResetVal, chr_mask: MaskResetVal};
    end else if (cfg_valid && cfg_ready) begin
      unique case (sbsm_cfg_idx_t'(cfg_index))
        CFG_WRAM_SEL: cfg_r.wram_sel_en <= cfg_data[0];
        CFG_PRG_MASK: cfg_r.prg_mask    <= cfg_data;
        CFG_CHR_MASK: cfg_r.chr_mask    <= cfg_data;
        default:      cfg_r             <= cfg_r;
      endcase
    end
  end

  sbsm_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .reg_select (s1_sel_r),
    .write_data (s1_data_r),
    .cpu_time   (s1_time_r),
    .regs_nxt   (regs_nxt),
    .ignored    (ignored)
  );

  sbsm_map u_map (
    .regs    (regs_nxt),
    .cfg     (cfg_r),
    .ignored (ignored),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_prg_bank_low  = res_r.prg_bank_low;
  assign out_prg_bank_high = res_r.prg_bank_high;
  assign out_chr_bank_low  = res_r.chr_bank_low;
  assign out_chr_bank_high = res_r.chr_bank_high;
  assign out_mirror_mode   = res_r.mirror_mode;
  assign out_wram_enabled  = res_r.wram_enabled;
  assign out_wram_bank     = res_r.wram_bank;
  assign out_write_ignored = res_r.write_ignored;

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import sbsm_pkg::*;

  // Tracks the mapper state on each accepted write and holds the bank
  // mappings still owed by the block, oldest first.
  class mapper_scoreboard;
    logic [RegW-1:0]  regs [4];
    logic [RegW-1:0]  shift_buf;
    logic [CntW-1:0]  shift_cnt;
    logic [TimeW-1:0] last_reset;
    logic             wram_sel_en;
    logic [RegW-1:0]  prg_mask;
    logic [RegW-1:0]  chr_mask;
    sbsm_result_t     owed [$];
    int               errors;

    function new();
      regs[SEL_CTRL] = CtlResetVal;
      regs[SEL_CHR0] = '0;
      regs[SEL_CHR1] = '0;
      regs[SEL_PRG]  = '0;
      shift_buf   = '0;
      shift_cnt   = '0;
      last_reset  = '0;
      wram_sel_en = 1'b0;
      prg_mask    = MaskResetVal;
      chr_mask    = MaskResetVal;
      errors      = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [RegW-1:0] value);
      case (idx)
        CFG_WRAM_SEL: wram_sel_en = value[0];
        CFG_PRG_MASK: prg_mask = value;
        CFG_CHR_MASK: chr_mask = value;
        default: ;
      endcase
    endfunction

    function void record_write(logic [1:0] sel, logic [DataW-1:0] data,
                               logic [TimeW-1:0] stamp);
      sbsm_result_t   r;
      logic [TimeW-1:0] delta;
      logic [RegW-1:0]  ctl, chr0, chr1, prg, offs, bank, plo, phi, clo, chi;
      logic             ignored;
      delta   = stamp - last_reset;
      ignored = (delta < 2);
      if (!ignored) begin
        if (data[7]) begin
          regs[SEL_CTRL] = regs[SEL_CTRL] | 5'h0C;
          shift_buf  = '0;
          shift_cnt  = '0;
          last_reset = stamp;
        end else begin
          // serial load, LSB first; fifth bit commits to the selected register
          shift_buf[shift_cnt] = data[0];
          shift_cnt = shift_cnt + 1'b1;
          if (shift_cnt == 3'd5) begin
            regs[sel] = shift_buf;
            shift_buf = '0;
            shift_cnt = '0;
          end
        end
      end
      ctl  = regs[SEL_CTRL];
      chr0 = regs[SEL_CHR0];
      chr1 = regs[SEL_CHR1];
      prg  = regs[SEL_PRG];
      offs = chr0 & 5'h10;
      bank = {1'b0, prg[3:0]};
      case (sbsm_prg_mode_t'(ctl[3:2]))
        PRG_FIX_HIGH: begin
          plo = bank + offs;
          phi = 5'h0F + offs;
        end
        PRG_FIX_LOW: begin
          plo = offs;
          phi = bank + offs;
        end
        default: begin
          plo = (bank & 5'h0E) + offs;
          phi = plo + 1'b1;
        end
      endcase
      if (ctl[4]) begin
        clo = chr0;
        chi = chr1;
      end else begin
        clo = chr0 & 5'h1E;
        chi = clo | 5'h01;
      end
      r.prg_bank_low  = plo & prg_mask;
      r.prg_bank_high = phi & prg_mask;
      r.chr_bank_low  = clo & chr_mask;
      r.chr_bank_high = chi & chr_mask;
      r.mirror_mode   = ctl[1:0];
      r.wram_enabled  = ~prg[4];
      r.wram_bank     = wram_sel_en ? (ctl[4] ? chr0[4] : chr0[3]) : 1'b0;
      r.write_ignored = ignored;
      owed.push_back(r);
    endfunction

    function void compare_field(string name, logic [RegW-1:0] want,
                                logic [RegW-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_mapping(sbsm_result_t got);
      sbsm_result_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, got %h", $time, got);
        return;
      end
      want = owed.pop_front();
      compare_field("prg_bank_low", want.prg_bank_low, got.prg_bank_low);
      compare_field("prg_bank_high", want.prg_bank_high, got.prg_bank_high);
      compare_field("chr_bank_low", want.chr_bank_low, got.chr_bank_low);
      compare_field("chr_bank_high", want.chr_bank_high, got.chr_bank_high);
      compare_field("mirror_mode", want.mirror_mode, got.mirror_mode);
      compare_field("wram_enabled", want.wram_enabled, got.wram_enabled);
      compare_field("wram_bank", want.wram_bank, got.wram_bank);
      compare_field("write_ignored", want.write_ignored, got.write_ignored);
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  localparam int unsigned NumWrites = 1150;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_reg_select;
  logic [DataW-1:0] in_write_data;
  logic [TimeW-1:0] in_cpu_time;
  logic             out_valid;
  logic             out_stall;
  logic [RegW-1:0]  out_prg_bank_low;
  logic [RegW-1:0]  out_prg_bank_high;
  logic [RegW-1:0]  out_chr_bank_low;
  logic [RegW-1:0]  out_chr_bank_high;
  logic [1:0]       out_mirror_mode;
  logic             out_wram_enabled;
  logic             out_wram_bank;
  logic             out_write_ignored;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [RegW-1:0]  cfg_data;

  mapper_scoreboard sb = new();
  logic             calm;
  logic [TimeW-1:0] cur_time;
  int unsigned      sent;

  serial_bank_switch_mapper u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_reg_select     (in_reg_select),
    .in_write_data     (in_write_data),
    .in_cpu_time       (in_cpu_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_prg_bank_low  (out_prg_bank_low),
    .out_prg_bank_high (out_prg_bank_high),
    .out_chr_bank_low  (out_chr_bank_low),
    .out_chr_bank_high (out_chr_bank_high),
    .out_mirror_mode   (out_mirror_mode),
    .out_wram_enabled  (out_wram_enabled),
    .out_wram_bank     (out_wram_bank),
    .out_write_ignored (out_write_ignored),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 19);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_mapping({out_prg_bank_low, out_prg_bank_high, out_chr_bank_low,
                          out_chr_bank_high, out_mirror_mode, out_wram_enabled,
                          out_wram_bank, out_write_ignored});
      end
      if (in_valid && !in_stall) begin
        sb.record_write(in_reg_select, in_write_data, in_cpu_time);
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_register(cfg_index, cfg_data);
      end
    end
  end

  task automatic send_write(logic [1:0] sel, logic [DataW-1:0] data,
                            logic [TimeW-1:0] stamp);
    in_valid      <= 1'b1;
    in_reg_select <= sel;
    in_write_data <= data;
    in_cpu_time   <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // five serial writes; only the last one's select picks the register
  task automatic load_reg(logic [1:0] sel, logic [RegW-1:0] value, int unsigned max_step);
    for (int i = 0; i < 5; i++) begin
      cur_time = cur_time + $urandom_range(1, max_step);
      send_write((i == 4) ? sel : 2'($urandom_range(0, 3)),
                 {1'b0, 6'($urandom), value[i]}, cur_time);
    end
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic program_register(sbsm_cfg_idx_t idx, logic [RegW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(int unsigned phase);
    case (phase)
      0: begin
        program_register(CFG_WRAM_SEL, 5'h01);
        program_register(CFG_PRG_MASK, 5'h1F);
        program_register(CFG_CHR_MASK, 5'h1F);
      end
      1: begin
        // upper data bits of the one-bit register are dropped
        program_register(CFG_WRAM_SEL, 5'h1E);
        program_register(CFG_PRG_MASK, 5'h00);
        program_register(CFG_CHR_MASK, 5'h00);
      end
      2: begin
        program_register(CFG_WRAM_SEL, 5'h1F);
        program_register(CFG_PRG_MASK, 5'h07);
        program_register(CFG_CHR_MASK, 5'h0F);
        program_register(CFG_UNUSED, 5'($urandom));
      end
      3: begin
        program_register(CFG_WRAM_SEL, 5'h00);
        program_register(CFG_PRG_MASK, 5'h1F);
        program_register(CFG_CHR_MASK, 5'h03);
      end
      default: begin
        program_register(CFG_UNUSED, 5'($urandom));
        program_register(CFG_WRAM_SEL, 5'($urandom));
        program_register(CFG_PRG_MASK, 5'($urandom));
        program_register(CFG_CHR_MASK, 5'($urandom));
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned next_phase;
    int unsigned pick;
    int unsigned waited;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_reg_select = '0;
    in_write_data = '0;
    in_cpu_time   = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_WRAM_SEL;
    cfg_data      = '0;
    calm          = 1'b0;
    sent          = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    phase = 0;
    apply_settings(phase);

    // directed: busy window right after reset, mode loads, reset write, wrap
    send_write(SEL_PRG, 8'hFF, 32'd0);
    send_write(SEL_CTRL, 8'h01, 32'd1);
    cur_time = 32'd1;
    load_reg(SEL_CTRL, 5'h0B, 1);
    load_reg(SEL_PRG, 5'h1F, 1);
    load_reg(SEL_CHR0, 5'h1A, 1);
    cur_time = cur_time + 1;
    send_write(SEL_CHR1, 8'h80, cur_time);
    send_write(SEL_CTRL, 8'h7E, cur_time + 1);
    send_write(SEL_CHR0, 8'hFF, 32'hFFFF_FFFF);
    send_write(SEL_PRG, 8'h00, 32'h0000_0000);
    send_write(SEL_CHR1, 8'h7F, 32'hFFFF_FFF0);
    cur_time = 32'hFFFF_FFF1;

    next_phase = 230;
    while (sent < NumWrites) begin
      if (sent >= next_phase) begin
        quiesce();
        phase++;
        apply_settings(phase);
        next_phase += 230;
      end
      calm = (sent >= 400 && sent < 600);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        load_reg(2'($urandom_range(0, 3)), 5'($urandom), 5);
      end else if (pick < 82) begin
        cur_time = cur_time + $urandom_range(1, 5);
        send_write(2'($urandom), {1'b1, 7'($urandom)}, cur_time);
        if ($urandom_range(0, 1)) begin
          // lands inside the busy window
          send_write(2'($urandom), 8'($urandom), cur_time + $urandom_range(0, 1));
        end
      end else if (pick < 92) begin
        cur_time = cur_time + $urandom_range(1, 5);
        send_write(2'($urandom), {1'b0, 7'($urandom)}, cur_time);
      end else begin
        cur_time = $urandom;
        send_write(2'($urandom), 8'($urandom), cur_time);
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      if (sb.pending() != 0) begin
        $display("%0t: %0d results expected, 0 received", $time, sb.pending());
      end
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
